// File: hw/rtl/vmsq_pkg.sv
// vmsq_pkg: shared types and constants for the vector magnitude block
// sequencer state encoding, the fixed polynomial coefficients and the scale and rounding constants
// no dependencies
package vmsq_pkg;

    typedef enum logic [13:0] {
        ST_IDLE  = 14'b00000000000001,
        ST_SQX   = 14'b00000000000010,
        ST_SQY   = 14'b00000000000100,
        ST_NORM  = 14'b00000000001000,
        ST_P1    = 14'b00000000010000,
        ST_P2    = 14'b00000000100000,
        ST_P3    = 14'b00000001000000,
        ST_P4    = 14'b00000010000000,
        ST_P5    = 14'b00000100000000,
        ST_P6    = 14'b00001000000000,
        ST_P7    = 14'b00010000000000,
        ST_SHIFT = 14'b00100000000000,
        ST_SCALE = 14'b01000000000000,
        ST_SPARE = 14'b10000000000000
    } state_t;

    localparam logic [15:0] POLY_K4    = 16'hA000;
    localparam logic [15:0] POLY_K6    = 16'hB333;
    localparam logic [15:0] SQRT_HALF  = 16'hB505;
    localparam logic [31:0] ROUND_HALF = 32'h0000_8000;

endpackage

// File: hw/rtl/vector_magnitude_sqrt_approx.sv
// vector_magnitude_sqrt_approx: approximate length of a 2-d offset vector
// depends on vmsq_pkg and vmsq_mul
//
// usage:
//   input channel: in_valid/in_ready with offset_x, offset_y (24-bit signed).
//   output channel: out_valid/out_ready with magnitude (16-bit).
//   one request is processed at a time; in_ready is high only while the
//   sequencer is idle.
//   sums of zero or one skip the normalizer and the series and go straight
//   to the shift and scale steps. the normalizer shifts by 16, 8, 4, 2 or 1
//   bits per step, so its run depends on the sum. every product goes through
//   the one shared 16x16 multiplier, one product at a time, in the order
//   squares, series terms, correction and final scale.
//   the result sits in an output register; a new request can be accepted
//   while it waits. if the receiver stalls and the register is still full
//   when the next result is ready, the sequencer holds in its last step.
//   reset (rst_n low, asynchronous) returns the sequencer to idle and
//   clears out_valid.
module vector_magnitude_sqrt_approx (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [23:0] offset_x,
    input  logic [23:0] offset_y,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] magnitude
);

    vmsq_pkg::state_t state_reg, state_next;

    logic [15:0] ax_reg, ax_next;
    logic [15:0] ay_reg, ay_next;
    logic [31:0] norm_reg, norm_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [15:0] c_reg, c_next;
    logic [15:0] t_reg, t_next;
    logic [15:0] acc_reg, acc_next;
    logic [15:0] q_reg, q_next;
    logic        out_valid_reg, out_valid_next;
    logic [15:0] mag_reg, mag_next;

    logic [15:0] mul_a;
    logic [15:0] mul_b;
    logic [31:0] mul_add;
    logic [31:0] prod;

    logic [15:0] xs;
    logic [15:0] ys;
    logic [15:0] c_new;
    logic [15:0] u_new;
    logic [31:0] diff;
    logic        out_free;

    assign xs       = offset_x[23:8];
    assign ys       = offset_y[23:8];
    assign c_new    = ~norm_reg[31:16];
    assign u_new    = prod[31:16];
    assign diff     = norm_reg - prod;
    assign out_free = !out_valid_reg || out_ready;

    assign in_ready  = (state_reg == vmsq_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;
    assign magnitude = mag_reg;

    vmsq_mul u_mul (
        .a      (mul_a),
        .b      (mul_b),
        .addend (mul_add),
        .result (prod)
    );

    // operand selection for the shared multiplier
    always_comb
    begin
        mul_a   = t_reg;
        mul_b   = c_reg;
        mul_add = '0;
        unique case (state_reg)
            vmsq_pkg::ST_SQX:
            begin
                mul_a = ax_reg;
                mul_b = ax_reg;
            end
            vmsq_pkg::ST_SQY:
            begin
                mul_a   = ay_reg;
                mul_b   = ay_reg;
                mul_add = norm_reg;
            end
            vmsq_pkg::ST_P4:
            begin
                mul_b = vmsq_pkg::POLY_K4;
            end
            vmsq_pkg::ST_P6:
            begin
                mul_b = vmsq_pkg::POLY_K6;
            end
            vmsq_pkg::ST_P7:
            begin
                mul_a = q_reg;
                mul_b = q_reg;
            end
            vmsq_pkg::ST_SCALE:
            begin
                mul_a   = q_reg;
                mul_b   = vmsq_pkg::SQRT_HALF;
                mul_add = vmsq_pkg::ROUND_HALF;
            end
            default:
            begin
                mul_a   = t_reg;
                mul_b   = c_reg;
                mul_add = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        ax_next        = ax_reg;
        ay_next        = ay_reg;
        norm_next      = norm_reg;
        cnt_next       = cnt_reg;
        c_next         = c_reg;
        t_next         = t_reg;
        acc_next       = acc_reg;
        q_next         = q_reg;
        out_valid_next = out_valid_reg;
        mag_next       = mag_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            vmsq_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    // absolute values; -32768 maps to 0x8000
                    ax_next    = xs[15] ? (~xs + 16'd1) : xs;
                    ay_next    = ys[15] ? (~ys + 16'd1) : ys;
                    cnt_next   = '0;
                    state_next = vmsq_pkg::ST_SQX;
                end
            end
            vmsq_pkg::ST_SQX:
            begin
                norm_next  = prod;
                state_next = vmsq_pkg::ST_SQY;
            end
            vmsq_pkg::ST_SQY:
            begin
                norm_next = prod;
                if (prod[31:1] == 31'd0)
                begin
                    // sum of zero or one passes straight through
                    q_next     = prod[15:0];
                    state_next = vmsq_pkg::ST_SHIFT;
                end
                else
                begin
                    state_next = vmsq_pkg::ST_NORM;
                end
            end
            vmsq_pkg::ST_NORM:
            begin
                if (norm_reg[31])
                begin
                    c_next     = c_new;
                    t_next     = {1'b0, c_new[15:1]};
                    acc_next   = {1'b0, c_new[15:1]};
                    state_next = vmsq_pkg::ST_P1;
                end
                else if (norm_reg[31:16] == 16'd0)
                begin
                    norm_next = {norm_reg[15:0], 16'd0};
                    cnt_next  = cnt_reg + 5'd16;
                end
                else if (norm_reg[31:24] == 8'd0)
                begin
                    norm_next = {norm_reg[23:0], 8'd0};
                    cnt_next  = cnt_reg + 5'd8;
                end
                else if (norm_reg[31:28] == 4'd0)
                begin
                    norm_next = {norm_reg[27:0], 4'd0};
                    cnt_next  = cnt_reg + 5'd4;
                end
                else if (norm_reg[31:30] == 2'd0)
                begin
                    norm_next = {norm_reg[29:0], 2'd0};
                    cnt_next  = cnt_reg + 5'd2;
                end
                else
                begin
                    norm_next = {norm_reg[30:0], 1'b0};
                    cnt_next  = cnt_reg + 5'd1;
                end
            end
            vmsq_pkg::ST_P1:
            begin
                t_next     = {2'd0, prod[31:18]};
                acc_next   = acc_reg + {2'd0, prod[31:18]};
                state_next = vmsq_pkg::ST_P2;
            end
            vmsq_pkg::ST_P2:
            begin
                t_next     = {1'b0, prod[31:17]};
                acc_next   = acc_reg + {1'b0, prod[31:17]};
                state_next = vmsq_pkg::ST_P3;
            end
            vmsq_pkg::ST_P3:
            begin
                t_next     = prod[31:16];
                state_next = vmsq_pkg::ST_P4;
            end
            vmsq_pkg::ST_P4:
            begin
                t_next     = u_new;
                acc_next   = acc_reg + u_new;
                state_next = vmsq_pkg::ST_P5;
            end
            vmsq_pkg::ST_P5:
            begin
                t_next     = u_new;
                state_next = vmsq_pkg::ST_P6;
            end
            vmsq_pkg::ST_P6:
            begin
                // first estimate is the complement of the series sum
                q_next     = ~(acc_reg + u_new);
                state_next = vmsq_pkg::ST_P7;
            end
            vmsq_pkg::ST_P7:
            begin
                // newton step: add (norm - q*q) >>> 17, low 16 bits
                q_next     = q_reg + {diff[31], diff[31:17]};
                state_next = vmsq_pkg::ST_SHIFT;
            end
            vmsq_pkg::ST_SHIFT:
            begin
                q_next     = q_reg >> cnt_reg[4:1];
                state_next = vmsq_pkg::ST_SCALE;
            end
            vmsq_pkg::ST_SCALE:
            begin
                if (out_free)
                begin
                    mag_next       = cnt_reg[0] ? prod[31:16] : q_reg;
                    out_valid_next = 1'b1;
                    state_next     = vmsq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = vmsq_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= vmsq_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ax_reg   <= ax_next;
        ay_reg   <= ay_next;
        norm_reg <= norm_next;
        cnt_reg  <= cnt_next;
        c_reg    <= c_next;
        t_reg    <= t_next;
        acc_reg  <= acc_next;
        q_reg    <= q_next;
        mag_reg  <= mag_next;
    end

endmodule

// File: hw/rtl/vmsq_mul.sv
// vmsq_mul: shared 16x16 unsigned multiply-accumulate, result modulo 2^32
// used by every product step of the magnitude sequencer
// no dependencies
module vmsq_mul (
    input  logic [15:0] a,
    input  logic [15:0] b,
    input  logic [31:0] addend,
    output logic [31:0] result
);

    logic [31:0] prod;

    assign prod   = 32'(a) * 32'(b);
    assign result = prod + addend;

endmodule

// File: dv/vector_magnitude_sqrt_approx_test.sv
// vector_magnitude_sqrt_approx_test: self-checking bench for the vector magnitude block
// holds its own bit-exact predictor of the length approximation and checks every result in order
// depends on vmsq_pkg and the vector_magnitude_sqrt_approx rtl
module vector_magnitude_sqrt_approx_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT  = 4000;
    localparam int LONG_HOLD   = 300;
    localparam int RANDOM_REQS = 1950;

    typedef struct {
        logic [23:0] x;
        logic [23:0] y;
        logic [15:0] length;
    } pending_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [23:0] offset_x;
    logic [23:0] offset_y;
    logic        out_valid;
    logic        out_ready;
    logic [15:0] magnitude;

    pending_t expected_lengths[$];
    int       requests_sent = 0;
    int       results_checked = 0;
    int       failures = 0;
    int       idle_cycles = 0;
    int       hold_request = 0;
    bit       tx_no_gap = 1'b0;
    bit       rx_no_stall = 1'b0;

    vector_magnitude_sqrt_approx dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .offset_x  (offset_x),
        .offset_y  (offset_y),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .magnitude (magnitude)
    );

    always #10 clk = ~clk;

    // bit-exact approximation: series on the complemented mantissa, one correction, rescale
    function automatic logic [15:0] approx_length(input logic [23:0] x, input logic [23:0] y);
        logic signed [31:0] xw;
        logic signed [31:0] yw;
        logic signed [31:0] sdiff;
        logic [31:0]        sum;
        logic [31:0]        norm;
        logic [31:0]        c;
        logic [31:0]        t;
        logic [31:0]        u;
        logic [31:0]        acc;
        logic [31:0]        q;
        logic [31:0]        prod;
        logic [31:0]        corr;
        int unsigned        shifts;
        xw = $signed(x[23:8]);
        yw = $signed(y[23:8]);
        sum = xw * xw + yw * yw;
        if (sum <= 32'd1)
            return sum[15:0];
        norm = sum;
        shifts = 0;
        while (!norm[31])
        begin
            norm = norm << 1;
            shifts++;
        end
        c = {16'h0000, ~norm[31:16]};
        t = c >> 1;
        acc = t;
        prod = t * c;
        t = prod >> 18;
        acc = (acc + t) & 32'hFFFF;
        prod = t * c;
        t = prod >> 17;
        acc = (acc + t) & 32'hFFFF;
        prod = t * c;
        t = prod >> 16;
        prod = t * 32'(vmsq_pkg::POLY_K4);
        u = (prod >> 16) & 32'hFFFF;
        acc = (acc + u) & 32'hFFFF;
        prod = u * c;
        u = (prod >> 16) & 32'hFFFF;
        prod = u * 32'(vmsq_pkg::POLY_K6);
        u = (prod >> 16) & 32'hFFFF;
        acc = (acc + u) & 32'hFFFF;
        q = acc ^ 32'hFFFF;
        prod = q * q;
        sdiff = norm - prod;
        corr = sdiff >>> 17;
        q = (q + corr) & 32'hFFFF;
        if (shifts[0])
        begin
            t = q >> (shifts >> 1);
            prod = t * 32'(vmsq_pkg::SQRT_HALF) + vmsq_pkg::ROUND_HALF;
            q = (prod >> 16) & 32'hFFFF;
        end
        else
        begin
            q = (q >> (shifts >> 1)) & 32'hFFFF;
        end
        return q[15:0];
    endfunction

    // mix of extremes, full-range values and values of random size for varied shift counts
    function automatic logic [23:0] random_offset();
        logic [15:0] whole;
        int          pick;
        pick = $urandom_range(0, 9);
        whole = $urandom;
        if (pick == 0)
        begin
            case ($urandom_range(0, 3))
                0: return 24'h7FFFFF;
                1: return 24'h800000;
                2: return 24'hFFFFFF;
                default: return 24'h000000;
            endcase
        end
        if (pick >= 5)
            whole = $signed(whole) >>> $urandom_range(0, 15);
        return {whole, 8'($urandom)};
    endfunction

    task automatic send_offsets(input logic [23:0] x, input logic [23:0] y);
        int gap;
        gap = tx_no_gap ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        offset_x <= x;
        offset_y <= y;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic test_special_sums();
        send_offsets(24'h000000, 24'h000000);
        send_offsets(24'h0000FF, 24'hFFFF80);
        send_offsets(24'h000100, 24'h000000);
        send_offsets(24'h000000, 24'hFFFF00);
        send_offsets(24'hFFFFFF, 24'h0000FF);
        // both offsets at the negative limit: the sum wraps into bit 31
        send_offsets(24'h800000, 24'h800000);
        send_offsets(24'h8000FF, 24'h800055);
    endtask

    task automatic test_extreme_offsets();
        send_offsets(24'h7FFFFF, 24'h7FFFFF);
        send_offsets(24'h7FFFFF, 24'h800000);
        send_offsets(24'h800000, 24'h000000);
        send_offsets(24'h000000, 24'h7FFFFF);
        // small sums give long normalizing runs of both parities
        send_offsets(24'h000100, 24'h000100);
        send_offsets(24'h000200, 24'h000000);
        send_offsets(24'hFFFF00, 24'hFFFE00);
        send_offsets(24'h000300, 24'hFFFC00);
        send_offsets(24'h123456, 24'hFEDCBA);
        send_offsets(24'h555555, 24'hAAAAAA);
        send_offsets(24'hAAAAAA, 24'h555555);
    endtask

    task automatic test_output_backpressure();
        tx_no_gap = 1'b1;
        hold_request <= LONG_HOLD;
        repeat (10) send_offsets(random_offset(), random_offset());
        tx_no_gap = 1'b0;
    endtask

    task automatic test_random_offsets(input int count);
        for (int i = 0; i < count; i++)
        begin
            // stretches with no idling on either side
            if (i % 400 == 0)
            begin
                tx_no_gap = 1'b1;
                rx_no_stall = 1'b1;
            end
            else if (i % 400 == 120)
            begin
                tx_no_gap = 1'b0;
                rx_no_stall = 1'b0;
            end
            send_offsets(random_offset(), random_offset());
        end
        tx_no_gap = 1'b0;
        rx_no_stall = 1'b0;
    endtask

    // receiver: random stall after each result unless rx_no_stall is set, plus a long hold when requested
    always @(posedge clk)
    begin
        int stall_left;
        int hold_left;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_left = 0;
            hold_left = 0;
        end
        else
        begin
            if (hold_request > 0)
            begin
                hold_left = hold_request;
                hold_request <= 0;
            end
            if (out_valid && out_ready)
                stall_left = rx_no_stall ? 0 : $urandom_range(0, 8);
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // checker: predicts on each accepted request, compares each accepted result in order
    always @(posedge clk)
    begin
        pending_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_lengths.size() == 0)
                begin
                    if (failures < 10)
                        $display("unexpected result: magnitude=%h", magnitude);
                    failures++;
                end
                else
                begin
                    want = expected_lengths.pop_front();
                    results_checked++;
                    if (magnitude !== want.length)
                    begin
                        if (failures < 10)
                            $display("mismatch: x=%h y=%h expected %h got %h",
                                     want.x, want.y, want.length, magnitude);
                        failures++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                want.x = offset_x;
                want.y = offset_y;
                want.length = approx_length(offset_x, offset_y);
                expected_lengths.push_back(want);
                requests_sent++;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("timeout: no request or result moved for %0d cycles", IDLE_LIMIT);
            $display("vector_magnitude_sqrt_approx_test NOT OK");
            $finish;
        end
    end

    initial
    begin
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        offset_x <= 24'h000000;
        offset_y <= 24'h000000;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_special_sums();
        test_extreme_offsets();
        test_output_backpressure();
        test_random_offsets(RANDOM_REQS);
        in_valid <= 1'b0;

        while (expected_lengths.size() > 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        failures += expected_lengths.size();

        $display("sent %0d requests, checked %0d results: zero/one sums, wrapped sum, extremes,",
                 requests_sent, results_checked);
        $display("both shift parities, random idling and a long output stall");
        if (failures == 0)
            $display("vector_magnitude_sqrt_approx_test OK");
        else
            $display("vector_magnitude_sqrt_approx_test NOT OK");
        $finish;
    end

endmodule
